// ----- src/assert_macros.svh -----
// assertion macros shared by the rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CRC_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");
`define CRC_ASSERT_NR(name, clk, prop) \
  name: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define CRC_ASSERT(name, clk, rstn, prop)
`define CRC_ASSERT_NR(name, clk, prop)
`endif
`endif

// ----- src/crc_pkg.sv -----
// types and constants of the clipped read consensus caller
// no dependencies
package crc_pkg;

  localparam int unsigned MAX_READS_DEF = 16;
  localparam int unsigned MAX_LEN_DEF   = 256;

  localparam int unsigned CMD_W  = 2;
  localparam int unsigned BASE_W = 3;
  localparam int unsigned QUAL_W = 7;
  localparam int unsigned LEN_W  = 9;
  localparam int unsigned COL_W  = 10;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned POS_W  = 12;
  localparam int unsigned NCODES = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD    = 2'd0,
    CMD_CLEAR   = 2'd1,
    CMD_REQUEST = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_DONE  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SETUP, S_SINGLE, S_WALK, S_DRAIN, S_MAX, S_PICK, S_DIV, S_OUT
  } state_e;

endpackage

// ----- src/crc_in_if.sv -----
// input channel of the consensus caller: command word with load payload
// depends on crc_pkg
interface crc_in_if import crc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [BASE_W-1:0] base_code;
  logic [QUAL_W-1:0] base_quality;
  logic [LEN_W-1:0]  left_length;
  logic [LEN_W-1:0]  right_length;
  logic              end_of_read;

  modport source (output valid, cmd, base_code, base_quality, left_length, right_length,
                  end_of_read, input ready);
  modport sink (input valid, cmd, base_code, base_quality, left_length, right_length,
                end_of_read, output ready);
endinterface

// ----- src/crc_out_if.sv -----
// result channel of the consensus caller
// depends on crc_pkg
interface crc_out_if import crc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BASE_W-1:0] consensus_base;
  logic              final_column;
  logic [STAT_W-1:0] status;
  logic              overflow_seen;

  modport source (output valid, consensus_base, final_column, status, overflow_seen,
                  input ready);
  modport sink (input valid, consensus_base, final_column, status, overflow_seen,
                output ready);
endinterface

// ----- src/clipped_read_consensus_caller_top.sv -----
// clipped read consensus caller: read store in one sync memory, per column vote
// depends on crc_pkg, crc_in_if, crc_out_if, assert_macros.svh
//
//  channel | dir | words
//  in_i    | in  | cmd, base_code, base_quality, left_length, right_length, end_of_read
//  out_o   | out | consensus_base, final_column, status, overflow_seen (one per request)
//
// load, clear and ignored commands are handled in the idle state.
// a request scans the finished reads, sets up, walks them through the store port, finds the
// top vote count, visits the codes and divides quality sums of the tied codes with a bit
// serial divider (up to 8 codes), then outputs; a single read skips the vote, and an empty
// store or a finished column goes straight to the output.
// a result waits in the output register; the next word is taken meanwhile.
// reset is asynchronous active low; no clearing pass, store contents start undefined.
`include "assert_macros.svh"
module clipped_read_consensus_caller_top import crc_pkg::*; #(
  parameter int unsigned MAX_READS = MAX_READS_DEF,
  parameter int unsigned MAX_LEN   = MAX_LEN_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  crc_in_if.sink    in_i,
  crc_out_if.source out_o
);

  localparam int unsigned R_W  = $clog2(MAX_READS);
  localparam int unsigned RC_W = $clog2(MAX_READS + 1);
  localparam int unsigned L_W  = $clog2(MAX_LEN);
  localparam int unsigned LN_W = $clog2(MAX_LEN + 1);
  localparam int unsigned A_W  = R_W + L_W;
  localparam int unsigned D_W  = BASE_W + QUAL_W;
  localparam int unsigned V_W  = RC_W;
  localparam int unsigned Q_W  = QUAL_W + RC_W;
  localparam int unsigned C_W  = $clog2(NCODES);
  localparam int unsigned K_W  = $clog2(Q_W + 1);

  // read store
  logic [D_W-1:0] mem [MAX_READS * (2 ** L_W)];
  logic           mem_we, mem_re;
  logic [A_W-1:0] mem_waddr, mem_raddr;
  logic [D_W-1:0] mem_rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= {in_i.base_code, in_i.base_quality};
    end
    if (mem_re) begin
      mem_rdata_q <= mem[mem_raddr];
    end
  end

  // per read lengths
  logic [LEN_W-1:0] left_q  [MAX_READS];
  logic [LEN_W-1:0] right_q [MAX_READS];
  logic [LN_W-1:0]  len_q   [MAX_READS];

  state_e            state_q, state_d;
  logic [RC_W-1:0]   count_q;
  logic [COL_W-1:0]  col_q;
  logic              ovf_q;
  logic [R_W-1:0]    r_q;
  logic [C_W-1:0]    c_q;
  logic [LEN_W-1:0]  hil_q, lol_q, hir_q, lor_q;
  logic [LEN_W-1:0]  clip_q;
  logic              acc_vld_q;
  logic [V_W-1:0]    votes_q [NCODES];
  logic [Q_W-1:0]    qsum_q  [NCODES];
  logic [V_W-1:0]    most_q;
  logic              best_vld_q;
  logic [Q_W-1:0]    best_q_q;
  logic [C_W-1:0]    best_c_q;
  logic [V_W-1:0]    rem_q, dvs_q;
  logic [Q_W-1:0]    quo_q;
  logic [K_W-1:0]    kcnt_q;
  logic [BASE_W-1:0] res_base_q;
  logic              res_fin_q;
  status_e           res_stat_q;
  logic              out_vld_q;
  logic [BASE_W-1:0] out_base_q;
  logic              out_fin_q;
  status_e           out_stat_q;
  logic              out_ovf_q;

  logic in_acc;
  cmd_e cmd;
  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign cmd        = cmd_e'(in_i.cmd);

  logic            r_last;
  logic [R_W-1:0]  wr_r;
  logic            can_load;
  assign r_last   = (RC_W'(r_q) == count_q - 1'b1);
  assign wr_r     = count_q[R_W-1:0];
  assign can_load = (count_q < RC_W'(MAX_READS));

  // setup values
  logic             one_read;
  logic [LEN_W-1:0] clip_n;
  logic [COL_W-1:0] total_n;
  assign one_read = (count_q == RC_W'(1));
  assign clip_n   = one_read ? left_q[0] : lol_q;
  assign total_n  = one_read ? COL_W'(len_q[0]) : (COL_W'(lol_q) + COL_W'(lor_q));

  // column position of the walked read
  logic signed [POS_W-1:0] pos;
  logic                    pos_ok;
  assign pos = $signed(POS_W'(left_q[r_q])) - $signed(POS_W'(clip_q))
             + $signed(POS_W'(col_q));
  assign pos_ok = !pos[POS_W-1] && (pos < $signed(POS_W'(len_q[r_q])))
               && (pos < $signed(POS_W'(MAX_LEN)));

  // divider step
  logic [V_W:0]   rem_sh;
  logic           qbit;
  logic [Q_W-1:0] quo_n;
  assign rem_sh = {rem_q, quo_q[Q_W-1]};
  assign qbit   = (rem_sh >= {1'b0, dvs_q});
  assign quo_n  = {quo_q[Q_W-2:0], qbit};

  logic [V_W-1:0] votes_c;
  logic [V_W-1:0] most_n;
  assign votes_c = votes_q[c_q];
  assign most_n  = (votes_c > most_q) ? votes_c : most_q;

  logic div_last, c_last;
  assign div_last = (kcnt_q == K_W'(1));
  assign c_last   = (c_q == C_W'(NCODES - 1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && cmd == CMD_REQUEST) begin
          state_d = (count_q == '0) ? S_OUT : S_SCAN;
        end
      end
      S_SCAN:   if (r_last) state_d = S_SETUP;
      S_SETUP: begin
        if (col_q >= total_n) state_d = S_OUT;
        else if (one_read)    state_d = S_SINGLE;
        else                  state_d = S_WALK;
      end
      S_SINGLE: state_d = S_OUT;
      S_WALK:   if (r_last) state_d = S_DRAIN;
      S_DRAIN:  state_d = S_MAX;
      S_MAX: begin
        if (c_last) state_d = (most_n == '0) ? S_OUT : S_PICK;
      end
      S_PICK: begin
        if (votes_c == most_q) state_d = S_DIV;
        else if (c_last)       state_d = S_OUT;
      end
      S_DIV: begin
        if (div_last) state_d = c_last ? S_OUT : S_PICK;
      end
      S_OUT:    if (!out_vld_q || out_o.ready) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // store port
  always_comb begin
    mem_we    = in_acc && cmd == CMD_LOAD && can_load && (len_q[wr_r] < LN_W'(MAX_LEN));
    mem_waddr = {wr_r, len_q[wr_r][L_W-1:0]};
    mem_re    = 1'b0;
    mem_raddr = {r_q, pos[L_W-1:0]};
    case (state_q)
      S_SETUP: begin
        mem_re    = 1'b1;
        mem_raddr = {{R_W{1'b0}}, col_q[L_W-1:0]};
      end
      S_WALK:  mem_re = pos_ok;
      default: mem_re = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      col_q     <= '0;
      ovf_q     <= 1'b0;
      acc_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
      for (int i = 0; i < MAX_READS; i++) len_q[i] <= '0;
    end else begin
      state_q   <= state_d;
      acc_vld_q <= (state_q == S_WALK) && pos_ok;
      if (state_q == S_OUT && (!out_vld_q || out_o.ready)) begin
        out_vld_q <= 1'b1;
        if (res_stat_q == ST_OK) col_q <= col_q + 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (in_acc) begin
        case (cmd)
          CMD_LOAD: begin
            col_q <= '0;
            if (!can_load) begin
              ovf_q <= 1'b1;
            end else begin
              if (len_q[wr_r] >= LN_W'(MAX_LEN)) ovf_q <= 1'b1;
              else len_q[wr_r] <= len_q[wr_r] + 1'b1;
              if (in_i.end_of_read) count_q <= count_q + 1'b1;
            end
          end
          CMD_CLEAR: begin
            count_q <= '0;
            col_q   <= '0;
            ovf_q   <= 1'b0;
            for (int i = 0; i < MAX_READS; i++) len_q[i] <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc && cmd == CMD_LOAD && can_load) begin
      left_q[wr_r]  <= in_i.left_length;
      right_q[wr_r] <= in_i.right_length;
    end
    if (acc_vld_q) begin
      for (int k = 0; k < NCODES; k++) begin
        if (mem_rdata_q[D_W-1 -: BASE_W] == BASE_W'(k)) begin
          votes_q[k] <= votes_q[k] + 1'b1;
          qsum_q[k]  <= qsum_q[k] + Q_W'(mem_rdata_q[QUAL_W-1:0]);
        end
      end
    end
    case (state_q)
      S_IDLE: begin
        r_q        <= '0;
        hil_q      <= '0;
        lol_q      <= '0;
        hir_q      <= '0;
        lor_q      <= '0;
        res_base_q <= '0;
        res_fin_q  <= 1'b0;
        res_stat_q <= ST_EMPTY;
      end
      S_SCAN: begin
        // running second largest, equal values counted apart
        if (hil_q <= left_q[r_q]) begin
          lol_q <= hil_q;
          hil_q <= left_q[r_q];
        end else if (lol_q < left_q[r_q]) begin
          lol_q <= left_q[r_q];
        end
        if (hir_q <= right_q[r_q]) begin
          lor_q <= hir_q;
          hir_q <= right_q[r_q];
        end else if (lor_q < right_q[r_q]) begin
          lor_q <= right_q[r_q];
        end
        r_q <= r_last ? '0 : r_q + 1'b1;
      end
      S_SETUP: begin
        clip_q     <= clip_n;
        res_stat_q <= (col_q >= total_n) ? ST_DONE : ST_OK;
        res_fin_q  <= (col_q >= total_n) ? 1'b0 : (col_q + 1'b1 == total_n);
        res_base_q <= '0;
        for (int k = 0; k < NCODES; k++) begin
          votes_q[k] <= '0;
          qsum_q[k]  <= '0;
        end
      end
      S_SINGLE: res_base_q <= mem_rdata_q[D_W-1 -: BASE_W];
      S_WALK: begin
        r_q <= r_q + 1'b1;
        c_q    <= '0;
        most_q <= '0;
      end
      S_MAX: begin
        most_q     <= most_n;
        c_q        <= c_q + 1'b1;
        best_vld_q <= 1'b0;
        best_c_q   <= '0;
      end
      S_PICK: begin
        if (votes_c == most_q) begin
          rem_q  <= '0;
          dvs_q  <= votes_c;
          quo_q  <= qsum_q[c_q];
          kcnt_q <= K_W'(Q_W);
        end else begin
          if (c_last) res_base_q <= BASE_W'(best_c_q);
          c_q <= c_q + 1'b1;
        end
      end
      S_DIV: begin
        rem_q  <= qbit ? V_W'(rem_sh - {1'b0, dvs_q}) : V_W'(rem_sh);
        quo_q  <= quo_n;
        kcnt_q <= kcnt_q - 1'b1;
        if (div_last) begin
          c_q <= c_q + 1'b1;
          if (!best_vld_q || quo_n > best_q_q) begin
            best_vld_q <= 1'b1;
            best_q_q   <= quo_n;
            best_c_q   <= c_q;
            if (c_last) res_base_q <= BASE_W'(c_q);
          end else if (c_last) begin
            res_base_q <= BASE_W'(best_c_q);
          end
        end
      end
      default: ;
    endcase
    if (state_q == S_OUT && (!out_vld_q || out_o.ready)) begin
      out_base_q <= res_base_q;
      out_fin_q  <= res_fin_q;
      out_stat_q <= res_stat_q;
      out_ovf_q  <= ovf_q;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.consensus_base = out_base_q;
  assign out_o.final_column   = out_fin_q;
  assign out_o.status         = out_stat_q;
  assign out_o.overflow_seen  = out_ovf_q;

  `CRC_ASSERT(a_out_from_out_state, clk_i, rst_ni, $rose(out_vld_q) |-> $past(state_q == S_OUT))
  `CRC_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= RC_W'(MAX_READS))
  `CRC_ASSERT(a_div_in_range, clk_i, rst_ni, (state_q == S_DIV) |-> (kcnt_q != '0 && dvs_q != '0))
  `CRC_ASSERT_NR(a_reset_idle, clk_i, !rst_ni |=> (state_q == S_IDLE && !out_vld_q))

endmodule
